[sv/mst_critical_edge_finder_macros.svh]
// Assertion macros for the critical edge finder.
// Included by the top level; the including module provides i_clk and i_rst_n.
`ifndef MST_CRITICAL_EDGE_FINDER_MACROS_SVH
`define MST_CRITICAL_EDGE_FINDER_MACROS_SVH

// Checked only while out of reset.
`define MCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, including during reset.
`define MCE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/mce_pkg.sv]
// Shared types and constants for the critical edge finder.
// No dependencies.
package mce_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;
    localparam int VTX_W   = 10;
    localparam int WGT_W   = 16;
    localparam int SUM_W   = 26;
    localparam int CNT_W   = 10;
    localparam int POS_W   = 16;

    typedef struct packed {
        logic [VTX_W-1:0] end_a;
        logic [VTX_W-1:0] end_b;
        logic [WGT_W-1:0] edge_weight;
        logic             last_edge;
    } t_mce_in;

    typedef struct packed {
        logic [CNT_W-1:0] needed_count;
        logic [SUM_W-1:0] needed_weight;
    } t_mce_out;

    typedef struct packed {
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic [WGT_W-1:0] w;
    } t_mce_edge;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [WGT_W-1:0] w;
    } t_mce_tree;

    typedef struct packed {
        logic             start;
        logic             skip_en;
        logic [POS_W-1:0] skip_pos;
        logic             record;
    } t_mce_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] taken;
        logic [SUM_W-1:0] sum;
    } t_mce_rsp;

    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] idx;
        t_mce_tree        entry;
    } t_mce_twr;

endpackage

[sv/mce_kruskal.sv]
// Kruskal tree builder with a union-find parent memory.
// Reads sorted edges from the edge memory of the top level; uses mce_pkg.
module mce_kruskal
    import mce_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_mce_req                           i_req,
    input  logic [$clog2(MAX_EDGES+1)-1:0]     i_total,
    input  logic [CNT_W-1:0]                   i_target,
    output logic [$clog2(MAX_EDGES+1)-1:0]     o_edge_addr,
    input  t_mce_edge                          i_edge_data,
    output t_mce_rsp                           o_rsp,
    output t_mce_twr                           o_twr
);

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int CMP_W = 18;

    typedef enum logic [2:0] {
        S_IDLE, S_CLR, S_FETCH, S_EWAIT, S_NORM, S_FA, S_FB, S_DONE
    } t_state;

    t_state             r_state;
    logic [VW:0]        r_k;
    logic [ECW-1:0]     r_i;
    logic [ECW-1:0]     r_skip;
    logic               r_skip_en;
    logic               r_record;
    logic [CNT_W-1:0]   r_taken;
    logic [SUM_W-1:0]   r_sum;
    logic [VTX_W-1:0]   r_a;
    logic [VTX_W-1:0]   r_b;
    logic [WGT_W-1:0]   r_w;
    logic [VW-1:0]      r_cur;
    logic [VW-1:0]      r_ra;
    logic [VW-1:0]      r_pq;

    logic [VW-1:0]      pm [MAX_VERTICES];
    logic [VW-1:0]      w_prd;
    logic               w_pwe;
    logic [VW-1:0]      w_pwa;
    logic [VW-1:0]      w_pwd;
    logic               w_take;

    always_comb begin
        w_prd  = r_pq;
        w_pwe  = 1'b0;
        w_pwa  = r_ra;
        w_pwd  = r_cur;
        w_take = 1'b0;
        unique case (r_state)
            S_CLR: begin
                w_pwe = 1'b1;
                w_pwa = r_k[VW-1:0];
                w_pwd = r_k[VW-1:0];
            end
            S_NORM: w_prd = VW'(r_a);
            S_FA: begin
                if (r_pq == r_cur) begin
                    w_prd = VW'(r_b);
                end
            end
            S_FB: begin
                if (r_pq == r_cur && r_ra != r_cur) begin
                    w_pwe  = 1'b1;
                    w_take = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            pm[w_pwa] <= w_pwd;
        end
        r_pq <= pm[w_prd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_skip_en <= i_req.skip_en;
                        r_skip    <= ECW'(i_req.skip_pos);
                        r_record  <= i_req.record;
                        r_k       <= '0;
                        r_state   <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == (VW+1)'(MAX_VERTICES - 1)) begin
                        r_i     <= '0;
                        r_taken <= '0;
                        r_sum   <= '0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    if (r_i >= i_total || r_taken >= i_target) begin
                        r_state <= S_DONE;
                    end else if (r_skip_en && r_i == r_skip) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_state <= S_EWAIT;
                    end
                end
                S_EWAIT: begin
                    r_a     <= i_edge_data.a;
                    r_b     <= i_edge_data.b;
                    r_w     <= i_edge_data.w;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (CMP_W'(r_a) >= CMP_W'(MAX_VERTICES)) begin
                        r_a <= VTX_W'(CMP_W'(r_a) - CMP_W'(MAX_VERTICES));
                    end else if (CMP_W'(r_b) >= CMP_W'(MAX_VERTICES)) begin
                        r_b <= VTX_W'(CMP_W'(r_b) - CMP_W'(MAX_VERTICES));
                    end else begin
                        r_cur   <= VW'(r_a);
                        r_state <= S_FA;
                    end
                end
                S_FA: begin
                    if (r_pq == r_cur) begin
                        r_ra    <= r_cur;
                        r_cur   <= VW'(r_b);
                        r_state <= S_FB;
                    end else begin
                        r_cur <= r_pq;
                    end
                end
                S_FB: begin
                    if (r_pq == r_cur) begin
                        if (w_take) begin
                            r_taken <= r_taken + 1'b1;
                            r_sum   <= r_sum + SUM_W'(r_w);
                        end
                        r_i     <= r_i + 1'b1;
                        r_state <= S_FETCH;
                    end else begin
                        r_cur <= r_pq;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_edge_addr     = r_i;
    assign o_rsp.done      = (r_state == S_DONE);
    assign o_rsp.taken     = r_taken;
    assign o_rsp.sum       = r_sum;
    assign o_twr.we        = w_take && r_record;
    assign o_twr.idx       = r_taken;
    assign o_twr.entry.pos = POS_W'(r_i);
    assign o_twr.entry.w   = r_w;

endmodule

[sv/mst_critical_edge_finder.sv]
// Top level of the critical edge finder: sorted edge memory, tree list and control.
// Uses mce_pkg, mce_kruskal and mst_critical_edge_finder_macros.svh.
//
//   channel | direction | handshake           | word
//   in      | input     | i_in_valid/o_in_stall  | t_mce_in
//   out     | output    | o_out_valid/i_out_stall| t_mce_out
//   cfg     | input     | i_cfg_valid/o_cfg_ready| vertex_count, 10 bits
//
// An edge into an empty memory is written in its accept cycle; one into a full memory is
// dropped; otherwise the input stalls while the write port moves stored edges of greater
// weight up. A last edge then runs 1 + T tree builds, T the tree size; each build first
// sweeps the parent memory, then fetches each sorted edge, normalises its ends and follows
// both find chains. Reset is synchronous and clears control state only.
// The input stalls from a word's acceptance until its insertion or result is done.
module mst_critical_edge_finder
    import mce_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_mce_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_mce_out         o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [VTX_W-1:0] i_cfg_data
);

    `include "mst_critical_edge_finder_macros.svh"

    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int TL_DEPTH = (MAX_VERTICES - 1 < 1023) ? MAX_VERTICES - 1 : 1023;
    localparam int TLW = (TL_DEPTH > 1) ? $clog2(TL_DEPTH) : 1;
    localparam int CAP_W = 18;

    typedef enum logic [3:0] {
        S_IDLE, S_SHIFT, S_PLACE, S_B0, S_B0W, S_TRIAL, S_TREAD, S_TW, S_OUT
    } t_state;

    t_state            r_state;
    logic [VTX_W-1:0]  r_vc;
    logic [ECW-1:0]    r_total;
    logic [ECW-1:0]    r_pos;
    t_mce_edge         r_new;
    logic              r_last;
    t_mce_edge         r_eq;
    t_mce_tree         r_tq;
    logic [CNT_W-1:0]  r_target;
    logic [CNT_W-1:0]  r_tree_n;
    logic [SUM_W-1:0]  r_tree_w;
    logic [CNT_W-1:0]  r_j;
    t_mce_tree         r_cur_t;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_wsum;
    t_mce_out          r_out;

    t_mce_edge         edge_mem [MAX_EDGES];
    t_mce_tree         tree_mem [TL_DEPTH];

    logic              w_ewe;
    logic [EIW-1:0]    w_ewa;
    t_mce_edge         w_ewd;
    logic [EIW-1:0]    w_era;
    logic [ECW-1:0]    w_eng_addr;
    t_mce_req          w_req;
    t_mce_rsp          w_rsp;
    t_mce_twr          w_twr;
    t_mce_edge         w_in_edge;
    logic              w_accept;
    logic [ECW-1:0]    w_vm1;
    logic [CAP_W-1:0]  w_cap;

    assign w_accept        = i_in_valid && !o_in_stall;
    assign w_in_edge.a     = i_in_data.end_a;
    assign w_in_edge.b     = i_in_data.end_b;
    assign w_in_edge.w     = i_in_data.edge_weight;
    assign w_vm1           = r_total - 1'b1;
    assign w_cap           = (r_vc > VTX_W'(1)) ? CAP_W'(r_vc) - 1'b1 : '0;

    always_comb begin
        w_ewe = 1'b0;
        w_ewa = r_pos[EIW-1:0];
        w_ewd = r_new;
        w_era = w_eng_addr[EIW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && r_total == '0) begin
                    w_ewe = 1'b1;
                    w_ewa = '0;
                    w_ewd = w_in_edge;
                end
                w_era = w_vm1[EIW-1:0];
            end
            S_SHIFT: begin
                w_ewe = 1'b1;
                if (r_eq.w > r_new.w) begin
                    w_ewd = r_eq;
                end
                w_era = EIW'(r_pos - 2'd2);
            end
            S_PLACE: w_ewe = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ewe) begin
            edge_mem[w_ewa] <= w_ewd;
        end
        r_eq <= edge_mem[w_era];
    end

    always_ff @(posedge i_clk) begin
        if (w_twr.we) begin
            tree_mem[w_twr.idx[TLW-1:0]] <= w_twr.entry;
        end
        r_tq <= tree_mem[r_j[TLW-1:0]];
    end

    always_comb begin
        w_req.start    = (r_state == S_B0) || (r_state == S_TREAD);
        w_req.skip_en  = (r_state == S_TREAD);
        w_req.skip_pos = r_tq.pos;
        w_req.record   = (r_state == S_B0);
    end

    mce_kruskal #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_kruskal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_total     (r_total),
        .i_target    (r_target),
        .o_edge_addr (w_eng_addr),
        .i_edge_data (r_eq),
        .o_rsp       (w_rsp),
        .o_twr       (w_twr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vc    <= VTX_W'(1);
            r_total <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_vc <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_new  <= w_in_edge;
                        r_last <= i_in_data.last_edge;
                        r_pos  <= r_total;
                        if (r_total == ECW'(MAX_EDGES)) begin
                            if (i_in_data.last_edge) begin
                                r_state <= S_B0;
                            end
                        end else if (r_total == '0) begin
                            r_total <= ECW'(1);
                            if (i_in_data.last_edge) begin
                                r_state <= S_B0;
                            end
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_eq.w > r_new.w) begin
                        r_pos <= r_pos - 1'b1;
                        if (r_pos == ECW'(1)) begin
                            r_state <= S_PLACE;
                        end
                    end else begin
                        r_total <= r_total + 1'b1;
                        r_state <= r_last ? S_B0 : S_IDLE;
                    end
                end
                S_PLACE: begin
                    r_total <= r_total + 1'b1;
                    r_state <= r_last ? S_B0 : S_IDLE;
                end
                S_B0: begin
                    r_target <= (w_cap > CAP_W'(TL_DEPTH)) ? CNT_W'(TL_DEPTH)
                                                          : CNT_W'(w_cap);
                    r_cnt   <= '0;
                    r_wsum  <= '0;
                    r_j     <= '0;
                    r_state <= S_B0W;
                end
                S_B0W: begin
                    if (w_rsp.done) begin
                        r_tree_n <= w_rsp.taken;
                        r_tree_w <= w_rsp.sum;
                        r_state  <= S_TRIAL;
                    end
                end
                S_TRIAL: begin
                    if (r_j == r_tree_n) begin
                        r_out.needed_count  <= r_cnt;
                        r_out.needed_weight <= r_wsum;
                        r_total             <= '0;
                        r_state             <= S_OUT;
                    end else begin
                        r_state <= S_TREAD;
                    end
                end
                S_TREAD: begin
                    r_cur_t <= r_tq;
                    r_state <= S_TW;
                end
                S_TW: begin
                    if (w_rsp.done) begin
                        if (w_rsp.taken < r_target || w_rsp.sum != r_tree_w) begin
                            r_cnt  <= r_cnt + 1'b1;
                            r_wsum <= r_wsum + SUM_W'(r_cur_t.w);
                        end
                        r_j     <= r_j + 1'b1;
                        r_state <= S_TRIAL;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    `MCE_ASSERT(a_total_bound, r_total <= ECW'(MAX_EDGES), "edge count above capacity")
    `MCE_ASSERT(a_no_early_result, w_accept |=> !o_out_valid, "result right after an input word")
    `MCE_ASSERT(a_taken_bound, w_rsp.done |-> w_rsp.taken <= r_target, "tree larger than target")
    `MCE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule
